[rtl/core/sra_pkg.sv]
package sra_pkg;

    localparam int ID_W       = 32;
    localparam int TIME_W     = 64;
    localparam int RES_LIMIT  = 32;   // most hits reported by one scan
    localparam int RES_CNT_W  = 6;    // holds 0..RES_LIMIT
    localparam int S_DATA_W   = 224;  // id, min, max, cutoff
    localparam int S_USER_W   = 1;    // op
    localparam int M_DATA_W   = 32;   // expired_id
    localparam int M_USER_W   = 3;    // kind, hit, status

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_SCAN     = 1'b1;
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_SCAN   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MARK,
        ST_SCAN,
        ST_DONE
    } sra_state_t;

    // search token passed from cell to cell
    typedef struct packed {
        logic tok;
        logic found;
    } sra_tok_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic occupied;
        logic append;
        logic mark;
        logic shift;
    } sra_cell_ctl_t;

endpackage

[rtl/core/sra_cell.sv]
module sra_cell
    import sra_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sra_cell_ctl_t            ctl,
    input  sra_tok_t                 tok_in,
    output sra_tok_t                 tok_out,
    input  logic [ID_W-1:0]          q_id,
    input  logic signed [TIME_W-1:0] q_lo,
    input  logic signed [TIME_W-1:0] q_hi,
    input  logic signed [TIME_W-1:0] cutoff,
    input  logic [ID_W-1:0]          nb_id,
    input  logic                     nb_hit,
    output logic [ID_W-1:0]          id_out,
    output logic                     hit_out
);

    logic [ID_W-1:0]          id_reg,  id_next;
    logic signed [TIME_W-1:0] min_reg, min_next;
    logic signed [TIME_W-1:0] max_reg, max_next;
    logic                     hit_reg, hit_next;
    sra_tok_t                 tok_reg, tok_next;
    logic                     match;

    assign match = tok_in.tok && !tok_in.found && ctl.occupied && (id_reg == q_id);

    always_comb
    begin
        id_next  = id_reg;
        min_next = min_reg;
        max_next = max_reg;
        hit_next = hit_reg;
        tok_next.tok   = tok_in.tok;
        tok_next.found = tok_in.found | match;
        if (match)
        begin
            if (q_lo < min_reg)
                min_next = q_lo;
            if (max_reg < q_hi)
                max_next = q_hi;
        end
        if (ctl.append)
        begin
            id_next  = q_id;
            min_next = q_lo;
            max_next = q_hi;
        end
        if (ctl.mark)
            hit_next = ctl.occupied && (max_reg < cutoff);
        if (ctl.shift)
        begin
            id_next  = nb_id;
            hit_next = nb_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            tok_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign tok_out = tok_reg;
    assign id_out  = id_reg;
    assign hit_out = hit_reg;

endmodule

[rtl/core/segment_retention_aggregator_unit.sv]
// Add: the id search token walks the cell row one cell per cycle, then the
//   ack beat follows.
// Scan: the row shifts toward cell 0 one entry per cycle, except while a second
//   hit waits on a stalled output beat, and the head is checked.
// One item at a time: the next item is taken only after the current one's last beat is issued. Reset (rst_n low,
//   asynchronous): table empty, idle, no beat out; entry payload not reset.
module segment_retention_aggregator_unit
    import sra_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [31:0] seg id, [95:32] block_min_time, [159:96] block_max_time,
    // [223:160] cutoff_time
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // [0] op
    input  logic [S_USER_W-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [31:0] expired_id
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // [0] kind, [1] hit, [2] status
    output logic [M_USER_W-1:0] m_axis_tuser,
    output logic                m_axis_tlast
);

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int STEP_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    sra_state_t state_reg, state_next;

    // current item
    logic [ID_W-1:0]          q_id_reg, q_id_next;
    logic signed [TIME_W-1:0] q_lo_reg, q_lo_next;
    logic signed [TIME_W-1:0] q_hi_reg, q_hi_next;
    logic signed [TIME_W-1:0] q_cut_reg, q_cut_next;
    logic                     inject_reg, inject_next;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [RES_CNT_W-1:0] nhits_reg, nhits_next;

    // pending result: during a scan it holds the latest hit until it is known
    // whether another hit follows (sets tlast)
    logic            res_kind_reg, res_kind_next;
    logic            res_hit_reg, res_hit_next;
    logic            res_status_reg, res_status_next;
    logic [ID_W-1:0] res_id_reg, res_id_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic            out_kind_reg, out_kind_next;
    logic            out_hit_reg, out_hit_next;
    logic            out_status_reg, out_status_next;
    logic            out_last_reg, out_last_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;

    // cell row
    sra_tok_t        tok [MAX_SEGMENTS+1];
    logic [ID_W-1:0] cell_id [MAX_SEGMENTS];
    logic            cell_hit [MAX_SEGMENTS];
    sra_cell_ctl_t   cell_ctl [MAX_SEGMENTS];

    logic s_fire;
    logic out_free;
    logic full;
    logic add_end;
    logic do_append;
    logic head_hit;
    logic scan_step;
    logic scan_end;
    logic emit_mid;
    logic emit_done;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign full     = (count_reg == CNT_W'(MAX_SEGMENTS));

    // token leaving the last cell ends the search
    assign add_end   = (state_reg == ST_ADD) && tok[MAX_SEGMENTS].tok;
    assign do_append = add_end && !tok[MAX_SEGMENTS].found && !full;

    // scan head: cell 0, capped at RES_LIMIT reported hits
    assign head_hit  = cell_hit[0] && (nhits_reg < RES_CNT_W'(RES_LIMIT));
    // a second hit while the previous one cannot leave stalls the shift
    assign scan_step = (state_reg == ST_SCAN) && !(head_hit && res_hit_reg && !out_free);
    assign scan_end  = scan_step && (step_reg == STEP_W'(MAX_SEGMENTS - 1));
    assign emit_mid  = scan_step && head_hit && res_hit_reg;
    assign emit_done = (state_reg == ST_DONE) && out_free;

    assign tok[0] = '{tok: inject_reg, found: 1'b0};

    for (genvar g = 0; g < MAX_SEGMENTS; g++)
    begin : g_cell
        logic [ID_W-1:0] nb_id;
        logic            nb_hit;

        if (g == MAX_SEGMENTS - 1)
        begin : g_tail
            assign nb_id  = '0;
            assign nb_hit = 1'b0;
        end
        else
        begin : g_body
            assign nb_id  = cell_id[g+1];
            assign nb_hit = cell_hit[g+1];
        end

        assign cell_ctl[g].occupied = (CNT_W'(g) < count_reg);
        assign cell_ctl[g].append   = do_append && (count_reg == CNT_W'(g));
        assign cell_ctl[g].mark     = (state_reg == ST_MARK);
        assign cell_ctl[g].shift    = scan_step;

        sra_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cell_ctl[g]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .q_id    (q_id_reg),
            .q_lo    (q_lo_reg),
            .q_hi    (q_hi_reg),
            .cutoff  (q_cut_reg),
            .nb_id   (nb_id),
            .nb_hit  (nb_hit),
            .id_out  (cell_id[g]),
            .hit_out (cell_hit[g])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                    state_next = (s_axis_tuser[0] == OP_ADD) ? ST_ADD : ST_MARK;
            end
            ST_ADD:
            begin
                if (add_end)
                    state_next = ST_DONE;
            end
            ST_MARK:
                state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_id_next       = q_id_reg;
        q_lo_next       = q_lo_reg;
        q_hi_next       = q_hi_reg;
        q_cut_next      = q_cut_reg;
        inject_next     = 1'b0;
        count_next      = count_reg;
        step_next       = step_reg;
        nhits_next      = nhits_reg;
        res_kind_next   = res_kind_reg;
        res_hit_next    = res_hit_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_hit_next    = out_hit_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_id_next     = out_id_reg;

        if (s_fire)
        begin
            q_id_next   = s_axis_tdata[31:0];
            q_lo_next   = s_axis_tdata[95:32];
            q_hi_next   = s_axis_tdata[159:96];
            q_cut_next  = s_axis_tdata[223:160];
            inject_next = (s_axis_tuser[0] == OP_ADD);
        end

        if (add_end)
        begin
            res_kind_next   = KIND_ACK;
            res_hit_next    = 1'b0;
            res_id_next     = '0;
            res_status_next = (!tok[MAX_SEGMENTS].found && full) ? STATUS_FULL : STATUS_OK;
            if (do_append)
                count_next = count_reg + CNT_W'(1);
        end

        if (state_reg == ST_MARK)
        begin
            step_next       = '0;
            nhits_next      = '0;
            res_kind_next   = KIND_SCAN;
            res_hit_next    = 1'b0;
            res_id_next     = '0;
            res_status_next = STATUS_OK;
        end

        if (scan_step)
        begin
            step_next = step_reg + STEP_W'(1);
            if (head_hit)
            begin
                res_hit_next = 1'b1;
                res_id_next  = cell_id[0];
                nhits_next   = nhits_reg + RES_CNT_W'(1);
            end
            if (scan_end)
                count_next = '0;
        end

        if (emit_mid || emit_done)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = res_kind_reg;
            out_hit_next    = res_hit_reg;
            out_status_next = res_status_reg;
            out_id_next     = res_id_reg;
            out_last_next   = emit_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inject_reg    <= 1'b0;
            count_reg     <= '0;
            step_reg      <= '0;
            nhits_reg     <= '0;
            res_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inject_reg    <= inject_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            nhits_reg     <= nhits_next;
            res_hit_reg   <= res_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_id_reg       <= q_id_next;
        q_lo_reg       <= q_lo_next;
        q_hi_reg       <= q_hi_next;
        q_cut_reg      <= q_cut_next;
        res_kind_reg   <= res_kind_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        out_kind_reg   <= out_kind_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_id_reg     <= out_id_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_id_reg;
    assign m_axis_tuser  = {out_status_reg, out_hit_reg, out_kind_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[rtl/core/sra_checker.sv]
module sra_checker
    import sra_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [M_USER_W-1:0] m_axis_tuser,
    input logic                m_axis_tlast
);

    // one item at a time: no second beat right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on back-to-back cycles");

    // an add gets a single ack beat, no hit
    a_ack_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_ACK) |-> m_axis_tlast && !m_axis_tuser[1])
        else $error("ack beat malformed");

    // hits come only from scans and never carry a full status
    a_hit_scan: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tuser[0] == KIND_SCAN)
            && (m_axis_tuser[2] == STATUS_OK))
        else $error("hit on non-scan beat");

    // a scan beat without a hit is the single none result
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_SCAN) && !m_axis_tuser[1]
            |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("none result malformed");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

endmodule

bind segment_retention_aggregator_unit sra_checker u_sra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
